// ===== rtl/lzwc_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwc_pkg
// shared constants, dictionary row layout and the controller/datapath
// command and status types of the lzw byte compressor
// ----------------------------------------------------------------------------
package lzwc_pkg;

	// dictionary size and derived widths
	localparam int unsigned DICT_ENTRIES = 4096;
	localparam int unsigned IDX_W        = $clog2(DICT_ENTRIES);
	localparam int unsigned USED_W       = IDX_W + 1;
	localparam int unsigned SINGLE_BYTES = 256;
	localparam int unsigned CLR_W        = $clog2(SINGLE_BYTES + 1);
	localparam int unsigned CODE_W       = 12;
	localparam int unsigned BYTE_W       = 8;

	// one dictionary row: symbol plus trie links, 0 means no entry
	typedef struct packed {
		logic [BYTE_W-1:0] sym;
		logic [IDX_W-1:0]  first;
		logic [IDX_W-1:0]  last;
		logic [IDX_W-1:0]  sib;
	} dict_row_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_PARENT,
		ST_WALK,
		ST_MISS,
		ST_LINK,
		ST_PARW,
		ST_TAIL
	} ctrl_state_t;

	// read address source
	typedef enum logic [1:0] {
		RD_PREFIX,
		RD_FIRST,
		RD_SIB,
		RD_LAST
	} rd_sel_t;

	// write address and data source
	typedef enum logic [1:0] {
		WR_CLEAR,
		WR_NEW,
		WR_LINK,
		WR_PARENT
	} wr_sel_t;

	typedef struct packed {
		logic    load_input;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    save_parent;
		logic    set_single;
		logic    set_hit;
		logic    push_out;
		logic    push_last;
		logic    bump_used;
		logic    restore;
		logic    clr_step;
	} lzwc_cmd_t;

	typedef struct packed {
		logic prefix_zero;
		logic first_end;
		logic sym_match;
		logic sib_end;
		logic room;
		logic parent_has_child;
		logic out_free;
		logic clr_done;
		logic in_last;
	} lzwc_status_t;

endpackage

// ===== rtl/lzwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzwc_ctrl
// sequencer of the compressor: dictionary clear, trie lookup, entry insert
// and code emission
// ----------------------------------------------------------------------------
module lzwc_ctrl import lzwc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         data_valid,
	output logic         data_stall,
	input  lzwc_status_t status,
	output lzwc_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign data_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.rd_sel = RD_PREFIX;
		cmd.wr_sel = WR_CLEAR;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = WR_CLEAR;
				cmd.clr_step = 1'b1;
				if (status.clr_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (data_valid) begin
					cmd.load_input = 1'b1;
					state_nxt      = ST_START;
				end
			end
			ST_START: begin
				// the root always holds every single byte
				if (status.prefix_zero) begin
					cmd.set_single = 1'b1;
					state_nxt      = ST_TAIL;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREFIX;
					state_nxt  = ST_PARENT;
				end
			end
			ST_PARENT: begin
				cmd.save_parent = 1'b1;
				if (status.first_end) begin
					state_nxt = ST_MISS;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_FIRST;
					state_nxt  = ST_WALK;
				end
			end
			ST_WALK: begin
				priority if (status.sym_match) begin
					cmd.set_hit = 1'b1;
					state_nxt   = ST_TAIL;
				end else if (status.sib_end) begin
					state_nxt = ST_MISS;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_SIB;
				end
			end
			ST_MISS: begin
				if (status.out_free) begin
					cmd.push_out = 1'b1;
					if (status.room) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WR_NEW;
						if (status.parent_has_child) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_LAST;
							state_nxt  = ST_LINK;
						end else begin
							state_nxt = ST_PARW;
						end
					end else begin
						cmd.set_single = 1'b1;
						state_nxt      = ST_TAIL;
					end
				end
			end
			ST_LINK: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_LINK;
				state_nxt  = ST_PARW;
			end
			ST_PARW: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WR_PARENT;
				cmd.bump_used  = 1'b1;
				cmd.set_single = 1'b1;
				state_nxt      = ST_TAIL;
			end
			ST_TAIL: begin
				if (!status.in_last) begin
					state_nxt = ST_IDLE;
				end else if (status.out_free) begin
					cmd.push_out  = 1'b1;
					cmd.push_last = 1'b1;
					cmd.restore   = 1'b1;
					state_nxt     = ST_CLEAR;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/lzwc_datapath.sv =====
// ----------------------------------------------------------------------------
// lzwc_datapath
// dictionary memory, prefix and fill registers, and the code output register
// ----------------------------------------------------------------------------
module lzwc_datapath import lzwc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                end_of_stream,
	input  logic                code_stall,
	output logic                code_valid,
	output logic [CODE_W-1:0]   code_word,
	output logic                last_code,
	input  lzwc_cmd_t           cmd,
	output lzwc_status_t        status
);

	dict_row_t dict_mem [DICT_ENTRIES];

	dict_row_t            rd_q;
	dict_row_t            prow_q;
	logic [IDX_W-1:0]     node_q;
	logic [IDX_W-1:0]     prefix_q;
	logic [USED_W-1:0]    used_q;
	logic [CLR_W-1:0]     clr_q;
	logic [BYTE_W-1:0]    byte_q;
	logic                 last_in_q;
	logic                 code_valid_q;
	logic [CODE_W-1:0]    code_q;
	logic                 last_code_q;

	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     wr_addr;
	dict_row_t            wr_row;
	dict_row_t            clr_row;
	logic [CLR_W-1:0]     clr_m1;
	logic [IDX_W-1:0]     new_idx;
	logic [IDX_W-1:0]     single_code;
	logic [CODE_W+IDX_W-1:0] prefix_ext;

	assign new_idx     = used_q[IDX_W-1:0];
	assign single_code = {{(IDX_W-BYTE_W){1'b0}}, byte_q} + IDX_W'(1);
	assign prefix_ext  = {{CODE_W{1'b0}}, prefix_q};
	assign clr_m1      = clr_q - CLR_W'(1);

	// reset image of the root and the single-byte rows
	always_comb begin
		clr_row.sym   = (clr_q == '0) ? '0 : clr_m1[BYTE_W-1:0];
		clr_row.first = (clr_q == '0) ? IDX_W'(1) : '0;
		clr_row.last  = (clr_q == '0) ? IDX_W'(SINGLE_BYTES) : '0;
		clr_row.sib   = ((clr_q != '0) && (clr_q < CLR_W'(SINGLE_BYTES))) ?
			(IDX_W'(clr_q) + IDX_W'(1)) : '0;
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_PREFIX: rd_addr = prefix_q;
			RD_FIRST:  rd_addr = rd_q.first;
			RD_SIB:    rd_addr = rd_q.sib;
			RD_LAST:   rd_addr = prow_q.last;
			default:   rd_addr = prefix_q;
		endcase
	end

	always_comb begin
		wr_row = clr_row;
		unique case (cmd.wr_sel)
			WR_CLEAR: begin
				wr_addr = IDX_W'(clr_q);
				wr_row  = clr_row;
			end
			WR_NEW: begin
				wr_addr    = new_idx;
				wr_row     = '0;
				wr_row.sym = byte_q;
			end
			WR_LINK: begin
				wr_addr    = prow_q.last;
				wr_row     = rd_q;
				wr_row.sib = new_idx;
			end
			WR_PARENT: begin
				wr_addr      = prefix_q;
				wr_row       = prow_q;
				wr_row.first = (prow_q.first == '0) ? new_idx : prow_q.first;
				wr_row.last  = new_idx;
			end
			default: begin
				wr_addr = IDX_W'(clr_q);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			dict_mem[wr_addr] <= wr_row;
		end
		if (cmd.rd_en) begin
			rd_q <= dict_mem[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_input) begin
			byte_q    <= data_byte;
			last_in_q <= end_of_stream;
		end
		if (cmd.save_parent) begin
			prow_q <= rd_q;
		end
		if (cmd.rd_en) begin
			node_q <= rd_addr;
		end
		if (cmd.push_out) begin
			code_q      <= prefix_ext[CODE_W-1:0];
			last_code_q <= cmd.push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q     <= '0;
			used_q       <= USED_W'(SINGLE_BYTES + 1);
			clr_q        <= '0;
			code_valid_q <= 1'b0;
		end else begin
			if (cmd.restore) begin
				prefix_q <= '0;
				used_q   <= USED_W'(SINGLE_BYTES + 1);
				clr_q    <= '0;
			end else begin
				if (cmd.set_single) begin
					prefix_q <= single_code;
				end else if (cmd.set_hit) begin
					prefix_q <= node_q;
				end
				if (cmd.bump_used) begin
					used_q <= used_q + USED_W'(1);
				end
				if (cmd.clr_step && (clr_q != CLR_W'(SINGLE_BYTES))) begin
					clr_q <= clr_q + CLR_W'(1);
				end
			end
			if (cmd.push_out) begin
				code_valid_q <= 1'b1;
			end else if (!code_stall) begin
				code_valid_q <= 1'b0;
			end
		end
	end

	assign code_valid = code_valid_q;
	assign code_word  = code_q;
	assign last_code  = last_code_q;

	always_comb begin
		status.prefix_zero      = (prefix_q == '0);
		status.first_end        = (rd_q.first == '0) ||
			(32'(rd_q.first) >= DICT_ENTRIES);
		status.sym_match        = (rd_q.sym == byte_q);
		status.sib_end          = (rd_q.sib == '0) || (32'(rd_q.sib) >= DICT_ENTRIES);
		status.room             = (used_q < USED_W'(DICT_ENTRIES));
		status.parent_has_child = (prow_q.first != '0);
		status.out_free         = !code_valid_q || !code_stall;
		status.clr_done         = (clr_q == CLR_W'(SINGLE_BYTES));
		status.in_last          = last_in_q;
	end

	// the prefix always names an entry that exists
	a_prefix_known: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, prefix_q} < used_q))
		else $error("prefix beyond filled entries");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q >= USED_W'(SINGLE_BYTES + 1)) && (used_q <= USED_W'(DICT_ENTRIES)))
		else $error("fill count out of range");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_out |-> (!code_valid_q || !code_stall))
		else $error("code pushed over a waiting code");

	a_new_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && (cmd.wr_sel == WR_NEW)) |-> status.room)
		else $error("entry added to a full dictionary");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.bump_used && !cmd.restore) |=> (used_q == $past(used_q) + USED_W'(1)))
		else $error("fill count did not advance");

endmodule

// ===== rtl/lzw_byte_compressor.sv =====
// ----------------------------------------------------------------------------
// lzw_byte_compressor
// 12-bit lzw coder with a child/sibling linked trie dictionary
// ----------------------------------------------------------------------------
// usage
//  - input channel: data_byte and end_of_stream with data_valid/data_stall;
//    a request is taken when data_valid is high and data_stall is low
//  - output channel: code_word and last_code with code_valid/code_stall;
//    each request gives zero, one or two codes (two on a miss at the last
//    byte), last_code marks the final code of a stream
//  - one byte at a time: a byte whose prefix is the empty root skips the
//    dictionary walk, otherwise k sibling rows are read in the dictionary
//    memory (one read and one write port, k up to 256), plus the miss, link
//    and parent-write steps for inserting a new entry; the sibling walk sets the rate
//  - first code appears in the cycle after the one that pushes it into the
//    output register
//  - a finished code waits in the output register while the next byte is
//    taken; the sequencer only pauses when it must push a code while the
//    register is still full and code_stall is high
//  - after reset and after every last byte the root and the 256 single-byte
//    rows are rewritten, one row a cycle, with data_stall high
//  - rows above 256 are never read before being written, the fill count
//    tracks them, so they need no clearing
// ----------------------------------------------------------------------------
module lzw_byte_compressor import lzwc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                data_valid,
	output logic                data_stall,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                end_of_stream,
	output logic                code_valid,
	input  logic                code_stall,
	output logic [CODE_W-1:0]   code_word,
	output logic                last_code
);

	// command and status between sequencer and datapath
	lzwc_cmd_t    cmd;
	lzwc_status_t status;

	// sequencer: clear pass, lookup walk, insert and emit steps
	lzwc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// dictionary memory, prefix, fill count and output register
	lzwc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.code_stall    (code_stall),
		.code_valid    (code_valid),
		.code_word     (code_word),
		.last_code     (last_code),
		.cmd           (cmd),
		.status        (status)
	);

endmodule
